/* hdl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Request and response formats, the search token that runs down the row of
// block cells, the update command that is broadcast to the cells, and the
// control states of the top level.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int ADDR_W       = 24;  // heap offsets and sizes
  localparam int LIMIT_W      = 25;  // break pointer and heap limit
  localparam int HANDLE_W     = 6;   // block handle field of the ports
  localparam int IDX_W        = 10;  // cell index inside the row
  localparam int CMP_W        = 11;  // wide enough for any block count
  localparam int HEADER_BYTES = 16;  // header placed in front of each payload

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_CALLOC = 2'd2,
    REQ_RESIZE = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [ADDR_W-1:0]   req_size;
    logic [ADDR_W-1:0]   elem_count;
    logic                has_block;
    logic [HANDLE_W-1:0] block_handle;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [HANDLE_W-1:0] out_handle;
    logic [ADDR_W-1:0]   payload_addr;
    logic [ADDR_W-1:0]   granted_size;
  } rsp_t;

  // Travels one cell per cycle; collects the first fitting free block and
  // the entry named by the request's handle.
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [ADDR_W-1:0]   hit_start;
    logic [ADDR_W-1:0]   hit_size;
    logic [ADDR_W-1:0]   h_start;
    logic [ADDR_W-1:0]   h_size;
  } token_t;

  // Table update, applied by every cell whose index matches.
  typedef struct packed {
    logic              wr_en;   // append a new block, marked in use
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_start;
    logic [ADDR_W-1:0] wr_size;
    logic              clr_en;  // reuse of a free block
    logic [IDX_W-1:0]  clr_idx;
    logic              set_en;  // block marked free
    logic [IDX_W-1:0]  set_idx;
    logic              rm_en;   // last block removed
    logic [IDX_W-1:0]  rm_idx;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LAUNCH,
    ST_WALK,
    ST_DECIDE
  } state_e;

endpackage

/* hdl/ffha_cell.sv */
// ----------------------------------------------------------------------------
// ffha_cell: one entry of the block table
// Holds start, size and free mark of one block and passes the search token
// on to the next cell, updating it when this entry is the first fit or the
// entry named by the handle.
// ----------------------------------------------------------------------------
module ffha_cell import ffha_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      live,
  input  cell_cmd_t cmd,
  input  token_t    tok_in,
  output token_t    tok_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [ADDR_W-1:0] start;
  logic [ADDR_W-1:0] size;
  logic              free;
  logic              free_next;
  token_t            tok_next;

  always_comb begin
    free_next = free;
    if (cmd.wr_en && cmd.wr_idx == MY_IDX) free_next = 1'b0;
    if (cmd.clr_en && cmd.clr_idx == MY_IDX) free_next = 1'b0;
    if (cmd.rm_en && cmd.rm_idx == MY_IDX) free_next = 1'b0;
    if (cmd.set_en && cmd.set_idx == MY_IDX) free_next = 1'b1;
  end

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && live && free && !tok_in.hit && size >= tok_in.size) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_idx   = MY_IDX;
      tok_next.hit_start = start;
      tok_next.hit_size  = size;
    end
    if (tok_in.valid && IDX_W'(tok_in.handle) == MY_IDX) begin
      tok_next.h_start = start;
      tok_next.h_size  = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free    <= 1'b0;
      tok_out <= '0;
    end else begin
      free    <= free_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && cmd.wr_idx == MY_IDX) begin
      start <= cmd.wr_start;
      size  <= cmd.wr_size;
    end
  end

endmodule

/* hdl/first_fit_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator over a block table
// Allocate, free, array allocate and resize on a table of blocks kept
// in address order, with a break pointer and a programmable heap limit.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req   (req_t)
//   rsp      out        rsp_valid / rsp_ready  rsp   (rsp_t)
//   cfg      in         cfg_valid / cfg_ready  cfg_data (heap_limit)
//
// Each request passes the states in order: the idle state in which it is
// accepted, the element product, the launch of the search token, the walk
// while the token passes every cell of the table, and the decide state
// that updates the table. One request is in work at a time.
// Reset (rst, synchronous) empties the table, clears the break pointer and
// sets the heap limit to its full range; no clearing pass is needed.
// A stalled response holds the block in its decide state; the next request
// is taken as soon as the response transaction has been registered.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  state_e             state;
  state_e             state_next;
  req_t               req_r;
  logic [2*ADDR_W-1:0] prod;
  token_t             res;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [LIMIT_W-1:0] brk;
  logic [LIMIT_W-1:0] brk_next;
  logic [LIMIT_W-1:0] limit;
  rsp_t               rsp_next;
  logic               commit;

  token_t             launch_tok;
  cell_cmd_t          cmd;
  token_t             chain [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] live;

  // Configuration is always accepted. The heap limit is expected to change
  // only while no request is in work.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_W'(1) << ADDR_W;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // The row of block cells. The token enters at cell 0 and leaves after the
  // last cell with the fit and handle lookups complete.
  assign chain[0] = launch_tok;
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    assign live[g] = count > CNT_W'(g);
    ffha_cell #(.INDEX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .live    (live[g]),
      .cmd     (cmd),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  // Size that a grant asks for: the product for array allocate.
  logic [ADDR_W-1:0] gsize;
  logic              calloc_bad;
  assign gsize = (req_r.req_type == REQ_CALLOC) ? prod[ADDR_W-1:0] : req_r.req_size;
  assign calloc_bad = (req_r.elem_count == '0) || (req_r.req_size == '0) ||
                      (prod[2*ADDR_W-1:ADDR_W] != '0);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (req_valid) state_next = ST_MUL;
      ST_MUL:    state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_WALK;
      ST_WALK:   if (chain[MAX_BLOCKS].valid) state_next = ST_DECIDE;
      ST_DECIDE: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the control: request ready and token launch.
  always_comb begin
    req_ready  = 1'b0;
    launch_tok = '0;
    unique case (state)
      ST_IDLE:   req_ready = 1'b1;
      ST_LAUNCH: begin
        launch_tok.valid  = 1'b1;
        launch_tok.size   = gsize;
        launch_tok.handle = req_r.block_handle;
      end
      default: ;
    endcase
  end

  assign commit = (state == ST_DECIDE) && (!rsp_valid || rsp_ready);

  // Decision on the collected search result, and the table update.
  logic [LIMIT_W:0]   nbrk;
  logic               g_hit;
  logic               g_app;
  logic               g_ok;
  logic               do_grant;
  logic               do_rel;
  logic               do_keep;
  logic               fail;
  logic               h_in;
  logic [CNT_W-1:0]   count_after;
  logic [IDX_W-1:0]   h_idx;

  assign nbrk  = {1'b0, brk} + (LIMIT_W+1)'(HEADER_BYTES) + (LIMIT_W+1)'(gsize);
  assign h_idx = IDX_W'(req_r.block_handle);
  assign h_in  = req_r.has_block && (CMP_W'(req_r.block_handle) < CMP_W'(count));

  always_comb begin
    g_hit = 1'b0;
    g_app = 1'b0;
    if (gsize != '0) begin
      if (res.hit) begin
        g_hit = 1'b1;
      end else if (count != CNT_W'(MAX_BLOCKS) && nbrk <= {1'b0, limit}) begin
        g_app = 1'b1;
      end
    end
    g_ok = g_hit || g_app;
  end

  always_comb begin
    do_grant = 1'b0;
    do_rel   = 1'b0;
    do_keep  = 1'b0;
    fail     = 1'b0;
    unique case (req_r.req_type)
      REQ_ALLOC: do_grant = 1'b1;
      REQ_FREE: begin
        if (req_r.has_block) begin
          if (!h_in) fail = 1'b1;
          else do_rel = 1'b1;
        end
      end
      REQ_CALLOC: begin
        if (calloc_bad) fail = 1'b1;
        else do_grant = 1'b1;
      end
      REQ_RESIZE: begin
        if (!req_r.has_block || req_r.req_size == '0) begin
          do_grant = 1'b1;
        end else if (!h_in) begin
          fail = 1'b1;
        end else if (res.h_size >= req_r.req_size) begin
          do_keep = 1'b1;
        end else begin
          do_grant = 1'b1;
          do_rel   = g_ok;
        end
      end
      default: fail = 1'b1;
    endcase
  end

  always_comb begin
    cmd         = '0;
    count_next  = count;
    brk_next    = brk;
    rsp_next    = '0;
    count_after = count;
    if (do_grant && g_hit) begin
      cmd.clr_en  = 1'b1;
      cmd.clr_idx = res.hit_idx;
    end
    if (do_grant && g_app) begin
      cmd.wr_en    = 1'b1;
      cmd.wr_idx   = IDX_W'(count);
      cmd.wr_start = brk[ADDR_W-1:0];
      cmd.wr_size  = gsize;
      count_after  = count + CNT_W'(1);
      count_next   = count_after;
      brk_next     = nbrk[LIMIT_W-1:0];
    end
    if (do_rel) begin
      if (CMP_W'(req_r.block_handle) + CMP_W'(1) == CMP_W'(count_after)) begin
        // The last block goes away and the break drops to its start.
        cmd.rm_en  = 1'b1;
        cmd.rm_idx = h_idx;
        count_next = CNT_W'(req_r.block_handle);
        brk_next   = LIMIT_W'(res.h_start);
      end else begin
        cmd.set_en  = 1'b1;
        cmd.set_idx = h_idx;
      end
    end
    if (fail || (do_grant && !g_ok)) begin
      rsp_next.status = 1'b1;
    end else if (do_keep) begin
      rsp_next.out_handle   = req_r.block_handle;
      rsp_next.payload_addr = res.h_start + ADDR_W'(HEADER_BYTES);
      rsp_next.granted_size = res.h_size;
    end else if (do_grant && g_hit) begin
      rsp_next.out_handle   = HANDLE_W'(res.hit_idx);
      rsp_next.payload_addr = res.hit_start + ADDR_W'(HEADER_BYTES);
      rsp_next.granted_size = res.hit_size;
    end else if (do_grant) begin
      rsp_next.out_handle   = HANDLE_W'(count);
      rsp_next.payload_addr = brk[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
      rsp_next.granted_size = gsize;
    end
    if (!commit) begin
      cmd        = '0;
      count_next = count;
      brk_next   = brk;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      brk       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      brk   <= brk_next;
      if (commit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) req_r <= req;
    if (state == ST_MUL) prod <= req_r.elem_count * req_r.req_size;
    if (state == ST_WALK && chain[MAX_BLOCKS].valid) res <= chain[MAX_BLOCKS];
    if (commit) rsp <= rsp_next;
  end

endmodule
